/* rtl/hlxd_pkg.sv */
// Shared types and constants for the length-prefixed XOR-checked deframer.
package hlxd_pkg;

    localparam logic [15:0] SYNC_WORD    = 16'hAA55;
    localparam logic [7:0]  SYNC_LOW     = SYNC_WORD[7:0];
    localparam logic [7:0]  SYNC_HIGH    = SYNC_WORD[15:8];
    localparam logic [15:0] ABS_MIN_LEN  = 16'd5;
    localparam logic [15:0] HEADER_BYTES = 16'd4;
    localparam logic [15:0] MIN_LEN_RESET = 16'd5;

    // Queue entry kinds.
    localparam logic [1:0] KIND_SHORT  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_BODY   = 2'd2;

    // Frame status codes on the last byte.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;    // body byte, or length low byte for a header
        logic [7:0] aux;     // length high byte for a header
        logic       last;
        logic [1:0] status;
    } entry_t;

endpackage

/* rtl/hlxd_front.sv */
// Front end: sync hunt, length decode and checksum, producing queue entries.
module hlxd_front
    import hlxd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_accept,
    input  logic [7:0]  in_byte,
    output logic        push,
    output entry_t      push_entry
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_LEN_HI = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic        prev_sync_reg, prev_sync_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] min_len_reg;
    logic [15:0] new_len;
    logic        body_last;

    assign new_len   = {in_byte, len_lo_reg};
    assign body_last = ({1'b0, seen_reg} + 17'd1) >= {1'b0, frame_len_reg};

    always_comb begin
        phase_next     = phase_reg;
        prev_sync_next = prev_sync_reg;
        len_lo_next    = len_lo_reg;
        frame_len_next = frame_len_reg;
        seen_next      = seen_reg;
        xor_next       = xor_reg;
        push           = 1'b0;
        push_entry     = '0;
        if (in_accept) begin
            case (phase_reg)
                PH_LEN_LO: begin
                    len_lo_next = in_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    frame_len_next = new_len;
                    push           = 1'b1;
                    if (new_len < min_len_reg || new_len < ABS_MIN_LEN) begin
                        push_entry.kind   = KIND_SHORT;
                        push_entry.last   = 1'b1;
                        push_entry.status = ST_SHORT;
                        phase_next        = PH_HUNT;
                        prev_sync_next    = 1'b0;
                        seen_next         = '0;
                        xor_next          = '0;
                    end else begin
                        push_entry.kind = KIND_HEADER;
                        push_entry.data = len_lo_reg;
                        push_entry.aux  = in_byte;
                        xor_next        = SYNC_LOW ^ SYNC_HIGH ^ len_lo_reg ^ in_byte;
                        seen_next       = HEADER_BYTES;
                        phase_next      = PH_BODY;
                    end
                end
                PH_BODY: begin
                    push            = 1'b1;
                    push_entry.kind = KIND_BODY;
                    push_entry.data = in_byte;
                    if (body_last) begin
                        push_entry.last   = 1'b1;
                        push_entry.status = (in_byte == xor_reg) ? ST_OK : ST_BAD_SUM;
                        phase_next        = PH_HUNT;
                        prev_sync_next    = 1'b0;
                        seen_next         = '0;
                        xor_next          = '0;
                    end else begin
                        xor_next  = xor_reg ^ in_byte;
                        seen_next = seen_reg + 16'd1;
                    end
                end
                default: begin
                    if (prev_sync_reg && in_byte == SYNC_HIGH) begin
                        prev_sync_next = 1'b0;
                        phase_next     = PH_LEN_LO;
                    end else begin
                        phase_next     = PH_HUNT;
                        prev_sync_next = (in_byte == SYNC_LOW);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            prev_sync_reg <= 1'b0;
            len_lo_reg    <= '0;
            frame_len_reg <= '0;
            seen_reg      <= '0;
            xor_reg       <= '0;
            min_len_reg   <= MIN_LEN_RESET;
        end else begin
            phase_reg     <= phase_next;
            prev_sync_reg <= prev_sync_next;
            len_lo_reg    <= len_lo_next;
            frame_len_reg <= frame_len_next;
            seen_reg      <= seen_next;
            xor_reg       <= xor_next;
            if (cfg_we) begin
                min_len_reg <= cfg_wdata;
            end
        end
    end

endmodule

/* rtl/hlxd_queue.sv */
// Small first-in first-out queue of entries between the front and back ends.
module hlxd_queue
    import hlxd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    entry_t                store [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/hlxd_back.sv */
// Back end: expands queue entries into output transactions behind an output register.
module hlxd_back
    import hlxd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       empty,
    input  entry_t     head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [1:0] user_reg;
    logic [1:0] beat_reg;
    logic       load;
    logic [7:0] data_sel;
    logic       last_sel;
    logic [1:0] user_sel;

    assign load = !empty && (!valid_reg || m_tready);
    // A header entry stays at the head until its fourth byte is loaded.
    assign pop  = load && (head.kind != KIND_HEADER || beat_reg == 2'd3);

    always_comb begin
        data_sel = head.data;
        last_sel = head.last;
        user_sel = head.status;
        case (head.kind)
            KIND_SHORT: begin
                data_sel = '0;
            end
            KIND_HEADER: begin
                last_sel = 1'b0;
                user_sel = ST_OK;
                case (beat_reg)
                    2'd0:    data_sel = SYNC_LOW;
                    2'd1:    data_sel = SYNC_HIGH;
                    2'd2:    data_sel = head.data;
                    default: data_sel = head.aux;
                endcase
            end
            default: begin
                data_sel = head.data;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            if (load && head.kind == KIND_HEADER) begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_sel;
            last_reg <= last_sel;
            user_reg <= user_sel;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

/* rtl/header_length_xor_deframer.sv */
// Top level of the sync-word, length-prefixed, XOR-checked frame deframer.
// A byte that yields a result is registered in the queue, then in the output register.
// Throughput: one byte per cycle unless the queue is full; good lengths emit four header bytes.
// The eight-entry queue between front and back end absorbs those header bursts, so the
// input never waits while the receiver keeps m_tready high.
// Reset: aresetn is synchronous, active low; it restarts the hunt, empties the queue
// and sets min_frame_length to 5.
module header_length_xor_deframer
    import hlxd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,    // min_frame_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [7:0] frame_byte
    output logic        m_tlast,      // frame_last
    output logic [1:0]  m_tuser       // [1:0] frame_status
);

    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    logic   empty;
    entry_t head;
    logic   in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && !full;

    hlxd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    hlxd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    hlxd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/hlxd_checker.sv */
// Port-level assertions for the deframer, bound to its top level.
module hlxd_checker
    import hlxd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // A stalled output transaction holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output transaction changed");

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Status is only nonzero on the last byte of a frame.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tlast)
        else $error("status set on a byte that is not last");

    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_SHORT |-> m_tdata == 8'd0 && m_tlast)
        else $error("short-frame result with nonzero byte");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

endmodule

bind header_length_xor_deframer hlxd_checker u_hlxd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
